FILE: rtl/gtt_pkg.sv
// shared types, widths and reset constants of the gated triangle tone generator
package gtt_pkg;

  // field and register widths
  localparam int unsigned PHASE_W    = 18;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned FREQ_W     = 15;
  localparam int unsigned AMP_W      = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // default number of fraction bits of the wave
  localparam int unsigned FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = RATE_W'(48000);
  localparam logic [FREQ_W-1:0]  TONE_FREQ_RST   = FREQ_W'(440);
  localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = AMP_W'(16384);
  localparam logic [PHASE_W-1:0] PERIOD_RST      = PHASE_W'(48000 / 440);

  // largest sample magnitude
  localparam logic [SAMPLE_W-2:0] SAMPLE_MAX = {(SAMPLE_W-1){1'b1}};

  // entries of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_TONE_FREQ   = 2'd1,
    REG_AMPLITUDE   = 2'd2
  } cfg_reg_e;

  // one input frame tick
  typedef struct packed {
    logic key_pressed;
    logic end_of_buffer;
  } in_t;

  // one output frame
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_of_buffer;
  } out_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic               compute;
    logic               last;
    logic [PHASE_W-1:0] phase;
  } job_t;

endpackage

FILE: rtl/gtt_fifo.sv
// short job queue between the front and the back
module gtt_fifo
  import gtt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/gtt_div.sv
// shared restoring divider, one quotient bit per cycle
module gtt_div #(
  parameter int unsigned QW = 18,
  parameter int unsigned DW = 18
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [$clog2(QW+1)-1:0]    steps_i,
  input  logic [DW-1:0]              rem_init_i,
  input  logic [QW-1:0]              num_i,
  input  logic [DW-1:0]              divisor_i,
  output logic                       busy_o,
  output logic [QW-1:0]              quot_o
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] num_q, num_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q;

  // one trial subtraction; the numerator register collects the quotient
  assign trial = {rem_q, num_q[QW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    num_d = num_q;
    div_d = div_q;
    if (start_i) begin
      cnt_d = steps_i;
      rem_d = rem_init_i;
      num_d = num_i;
      div_d = divisor_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      num_d = {num_q[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

endmodule

FILE: rtl/gtt_front.sv
// front part: takes frame ticks, tracks the phase and queues jobs
module gtt_front
  import gtt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  input  logic               cfg_hit_i,
  input  logic [PHASE_W-1:0] period_i,
  input  logic               period_busy_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output job_t               job_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W:0]   phase_inc;

  // hold off while the queue is full or the period is being recomputed
  assign in_stall_o = queue_full_i || period_busy_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // classify the tick
  assign job_o.compute = in_data_i.key_pressed;
  assign job_o.last    = in_data_i.end_of_buffer;
  assign job_o.phase   = phase_q;

  // phase advances on every transfer and restarts on a register write
  assign phase_inc = {1'b0, phase_q} + 1'b1;

  always_comb begin
    phase_d = phase_q;
    if (cfg_hit_i) begin
      phase_d = '0;
    end else if (push_o) begin
      phase_d = (phase_inc >= {1'b0, period_i}) ? '0 : phase_inc[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

FILE: rtl/gtt_back.sv
// back part: period recompute, triangle divide, gain scaling and output register
module gtt_back
  import gtt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_hit_i,
  input  logic [RATE_W-1:0]  sample_rate_i,
  input  logic [FREQ_W-1:0]  tone_freq_i,
  input  logic [AMP_W-1:0]   amplitude_i,
  input  logic               job_avail_i,
  input  job_t               job_i,
  output logic               job_pop_o,
  output logic [PHASE_W-1:0] period_o,
  output logic               period_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o
);

  localparam int unsigned RW  = FRAC_BITS + 2;
  localparam int unsigned QW  = (RW > PHASE_W) ? RW : PHASE_W;
  localparam int unsigned DW  = PHASE_W;
  localparam int unsigned CW  = $clog2(QW + 1);
  localparam int unsigned XW  = FRAC_BITS + 3;
  localparam int unsigned MGW = FRAC_BITS + 1;
  localparam int unsigned MW  = MGW + AMP_W;
  localparam int unsigned SW  = MW + 15;
  localparam int unsigned PW  = SW - (FRAC_BITS + 15);

  localparam logic [XW-1:0] ONE   = XW'(1) << FRAC_BITS;
  localparam logic [XW-1:0] TWO   = XW'(2) << FRAC_BITS;
  localparam logic [XW-1:0] THREE = XW'(3) << FRAC_BITS;
  localparam logic [XW-1:0] FOUR  = XW'(4) << FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PDIV  = 5'b00010,
    ST_TDIV  = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic                 pend_q, pend_d;
  logic [PHASE_W-1:0]   period_q, period_d;
  logic [SAMPLE_W-1:0]  held_q, held_d;
  logic                 out_valid_q, out_valid_d;
  logic                 last_q, last_d;
  logic [MW-1:0]        mul_q, mul_d;
  logic                 neg_q, neg_d;
  out_t                 out_q, out_d;

  logic                 div_start;
  logic [CW-1:0]        div_steps;
  logic [DW-1:0]        div_rem;
  logic [QW-1:0]        div_num;
  logic [DW-1:0]        div_divisor;
  logic                 div_busy;
  logic [QW-1:0]        div_quot;

  logic [XW-1:0]        r_x;
  logic [XW-1:0]        mag_x;
  logic                 mag_neg;
  logic [PHASE_W-1:0]   quot_period;
  logic [SW-1:0]        scaled;
  logic [PW-1:0]        prod;
  logic [SAMPLE_W-2:0]  sat;
  logic [SAMPLE_W-1:0]  sample;
  logic                 out_free;

  gtt_div #(
    .QW(QW),
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .rem_init_i (div_rem),
    .num_i      (div_num),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign period_o      = period_q;
  assign period_busy_o = pend_q || (state_q == ST_PDIV);
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;
  assign out_free      = !out_valid_q || !out_stall_i;

  // divider operands: period recompute has priority over frame jobs
  always_comb begin
    if (pend_q) begin
      div_steps   = CW'(PHASE_W);
      div_rem     = '0;
      div_num     = QW'(sample_rate_i) << (QW - RATE_W);
      div_divisor = (tone_freq_i == '0) ? DW'(1) : DW'(tone_freq_i);
    end else begin
      div_steps   = CW'(RW);
      div_rem     = job_i.phase;
      div_num     = '0;
      div_divisor = period_q;
    end
  end

  // period from the quotient, at least one
  assign quot_period = (div_quot[PHASE_W-1:0] == '0) ? PHASE_W'(1) : div_quot[PHASE_W-1:0];

  // fold the ramp into a triangle magnitude and sign
  assign r_x = XW'(div_quot[RW-1:0]);

  always_comb begin
    if (r_x > THREE) begin
      mag_x   = FOUR - r_x;
      mag_neg = 1'b1;
    end else if (r_x > TWO) begin
      mag_x   = r_x - TWO;
      mag_neg = 1'b1;
    end else if (r_x > ONE) begin
      mag_x   = TWO - r_x;
      mag_neg = 1'b0;
    end else begin
      mag_x   = r_x;
      mag_neg = 1'b0;
    end
  end

  // times 32767 as shift and subtract, then drop the fraction and saturate
  assign scaled = {mul_q, 15'b0} - SW'(mul_q);
  assign prod   = scaled[SW-1:FRAC_BITS+15];
  assign sat    = (prod > PW'(SAMPLE_MAX)) ? SAMPLE_MAX : prod[SAMPLE_W-2:0];
  assign sample = neg_q ? (SAMPLE_W'(0) - {1'b0, sat}) : {1'b0, sat};

  // sequencer
  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q || cfg_hit_i;
    period_d    = period_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    mul_d       = mul_q;
    neg_d       = neg_q;
    out_d       = out_q;
    div_start   = 1'b0;
    job_pop_o   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (pend_q) begin
          div_start = 1'b1;
          pend_d    = cfg_hit_i;
          state_d   = ST_PDIV;
        end else if (job_avail_i) begin
          job_pop_o = 1'b1;
          last_d    = job_i.last;
          if (job_i.compute) begin
            div_start = 1'b1;
            state_d   = ST_TDIV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_PDIV: begin
        if (!div_busy) begin
          period_d = quot_period;
          state_d  = ST_IDLE;
        end
      end
      ST_TDIV: begin
        if (!div_busy) begin
          mul_d   = mag_x[MGW-1:0] * amplitude_i;
          neg_d   = mag_neg;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        held_d  = sample;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d.left_sample    = held_q;
          out_d.right_sample   = held_q;
          out_d.last_of_buffer = last_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      period_q    <= PERIOD_RST;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      period_q    <= period_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    mul_q  <= mul_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

endmodule

FILE: rtl/gated_triangle_tone_generator.sv
// top level of the gated triangle tone generator: registers, front, queue and back
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o    in_data_i  (key_pressed, end_of_buffer)
//   out      output     out_valid_o/out_stall_i  out_data_o (left/right sample, last)
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// a frame with the key down is divided on the shared divider, which produces one quotient
// bit per cycle; a frame with the key up skips the divide and the scaling.
// a register write recomputes the period on the same divider, and input is stalled while
// it runs. reset loads the default registers and a period of 109.
// the queue holds two ticks and the output register lets the back finish while out stalls.
module gated_triangle_tone_generator
  import gtt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [RATE_W-1:0]  sample_rate_q;
  logic [FREQ_W-1:0]  tone_freq_q;
  logic [AMP_W-1:0]   amplitude_q;
  logic               cfg_hit;
  logic [PHASE_W-1:0] period;
  logic               period_busy;
  logic               push;
  job_t               push_job;
  logic               pop;
  job_t               head_job;
  logic               queue_full;
  logic               queue_empty;

  // register decode; an unknown index is ignored
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SAMPLE_RATE, REG_TONE_FREQ, REG_AMPLITUDE: cfg_hit = 1'b1;
        default:                                       cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SAMPLE_RATE_RST;
      tone_freq_q   <= TONE_FREQ_RST;
      amplitude_q   <= AMPLITUDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SAMPLE_RATE: sample_rate_q <= cfg_wdata_i[RATE_W-1:0];
        REG_TONE_FREQ:   tone_freq_q   <= cfg_wdata_i[FREQ_W-1:0];
        REG_AMPLITUDE:   amplitude_q   <= cfg_wdata_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  gtt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .cfg_hit_i     (cfg_hit),
    .period_i      (period),
    .period_busy_i (period_busy),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  gtt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (head_job),
    .full_o      (queue_full),
    .empty_o     (queue_empty)
  );

  gtt_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_hit_i     (cfg_hit),
    .sample_rate_i (sample_rate_q),
    .tone_freq_i   (tone_freq_q),
    .amplitude_i   (amplitude_q),
    .job_avail_i   (!queue_empty),
    .job_i         (head_job),
    .job_pop_o     (pop),
    .period_o      (period),
    .period_busy_o (period_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
